>>> src/fpd_pkg.sv
// ----------------------------------------------------------------------------
// fpd_pkg
// shared types and codes for the flight phase detector
// ----------------------------------------------------------------------------
package fpd_pkg;

    localparam int ACCEL_W = 16;
    localparam int ALT_W   = 24;
    localparam int DIST_W  = 23;
    localparam int HOLD_W  = 16;
    localparam int TIME_W  = 32;
    localparam int PHASE_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_ARMED  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_FLIGHT = 2'd2;
    localparam logic [PHASE_W-1:0] PH_LANDED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_LIFTOFF_ACCEL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFTOFF_HOLD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RISE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LANDING_ACCEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LANDING_WINDOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LANDING_HOLD   = 3'd5;

    localparam logic [ACCEL_W-1:0] RST_LIFTOFF_ACCEL  = 16'd12288;
    localparam logic [HOLD_W-1:0]  RST_LIFTOFF_HOLD   = 16'd100;
    localparam logic [DIST_W-1:0]  RST_MIN_RISE       = 23'd1000;
    localparam logic [ACCEL_W-1:0] RST_LANDING_ACCEL  = 16'd4915;
    localparam logic [DIST_W-1:0]  RST_LANDING_WINDOW = 23'd500;
    localparam logic [HOLD_W-1:0]  RST_LANDING_HOLD   = 16'd2000;

    typedef struct packed {
        logic [ACCEL_W-1:0] liftoff_accel;
        logic [HOLD_W-1:0]  liftoff_hold;
        logic [DIST_W-1:0]  min_rise;
        logic [ACCEL_W-1:0] landing_accel;
        logic [DIST_W-1:0]  landing_window;
        logic [HOLD_W-1:0]  landing_hold;
    } cfg_t;

    typedef struct packed {
        logic                     action;
        logic [ACCEL_W-1:0]       accel;
        logic signed [ALT_W-1:0]  alt;
        logic [TIME_W-1:0]        now;
    } item_t;

    typedef struct packed {
        logic [PHASE_W-1:0]       phase;
        logic signed [ALT_W-1:0]  peak;
        logic signed [ALT_W-1:0]  baseline;
        logic [TIME_W-1:0]        liftoff_time;
        logic [TIME_W-1:0]        landed_time;
        logic [TIME_W-1:0]        accel_hold_start;
        logic [TIME_W-1:0]        landing_hold_start;
    } state_t;

    typedef struct packed {
        logic [PHASE_W-1:0]       phase;
        logic                     liftoff_event;
        logic                     landed_event;
        logic signed [ALT_W-1:0]  peak;
        logic signed [ALT_W-1:0]  baseline;
        logic [TIME_W-1:0]        liftoff_time;
        logic [TIME_W-1:0]        landed_time;
    } result_t;

endpackage

>>> src/flight_phase_detector_unit.sv
// ----------------------------------------------------------------------------
// flight_phase_detector_unit
// tracks arm, liftoff and landing from arm commands and sensor samples
//
//   channel   handshake                  payload
//   item      item_valid / item_ready    action, accel_magnitude, altitude, now_ms
//   result    result_valid / result_ready phase, liftoff_event, landed_event,
//                                        peak_altitude, baseline_altitude,
//                                        liftoff_time, landed_time
//   config    cfg_write_en               cfg_index, cfg_data
//
// one word accepted per cycle while item_ready is high, one result word per item
// path from item accept to result valid: input register, then the state update
//   and result register in one pass
// reset: phase idle, all tracking state zero, config registers to defaults
// stalls: a held result keeps one more item in the input register, then
//   item_ready drops until the result is taken
// ----------------------------------------------------------------------------
module flight_phase_detector_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  logic                                  action,
    input  logic [fpd_pkg::ACCEL_W-1:0]           accel_magnitude,
    input  logic signed [fpd_pkg::ALT_W-1:0]      altitude,
    input  logic [fpd_pkg::TIME_W-1:0]            now_ms,

    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic [fpd_pkg::PHASE_W-1:0]           phase,
    output logic                                  liftoff_event,
    output logic                                  landed_event,
    output logic signed [fpd_pkg::ALT_W-1:0]      peak_altitude,
    output logic signed [fpd_pkg::ALT_W-1:0]      baseline_altitude,
    output logic [fpd_pkg::TIME_W-1:0]            liftoff_time,
    output logic [fpd_pkg::TIME_W-1:0]            landed_time,

    input  logic                                  cfg_write_en,
    input  logic [fpd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [fpd_pkg::CFG_DATA_W-1:0]        cfg_data
);

    fpd_pkg::cfg_t    cfg_reg;
    fpd_pkg::state_t  state_reg;
    fpd_pkg::state_t  state_next;
    fpd_pkg::item_t   stage_item_reg;
    logic             stage_valid_reg;
    fpd_pkg::result_t result_reg;
    fpd_pkg::result_t result_next;
    logic             result_valid_reg;
    logic             advance;

    assign advance    = stage_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !stage_valid_reg || advance;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.liftoff_accel  <= fpd_pkg::RST_LIFTOFF_ACCEL;
            cfg_reg.liftoff_hold   <= fpd_pkg::RST_LIFTOFF_HOLD;
            cfg_reg.min_rise       <= fpd_pkg::RST_MIN_RISE;
            cfg_reg.landing_accel  <= fpd_pkg::RST_LANDING_ACCEL;
            cfg_reg.landing_window <= fpd_pkg::RST_LANDING_WINDOW;
            cfg_reg.landing_hold   <= fpd_pkg::RST_LANDING_HOLD;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                fpd_pkg::CFG_LIFTOFF_ACCEL:
                    cfg_reg.liftoff_accel  <= cfg_data[fpd_pkg::ACCEL_W-1:0];
                fpd_pkg::CFG_LIFTOFF_HOLD:
                    cfg_reg.liftoff_hold   <= cfg_data[fpd_pkg::HOLD_W-1:0];
                fpd_pkg::CFG_MIN_RISE:
                    cfg_reg.min_rise       <= cfg_data[fpd_pkg::DIST_W-1:0];
                fpd_pkg::CFG_LANDING_ACCEL:
                    cfg_reg.landing_accel  <= cfg_data[fpd_pkg::ACCEL_W-1:0];
                fpd_pkg::CFG_LANDING_WINDOW:
                    cfg_reg.landing_window <= cfg_data[fpd_pkg::DIST_W-1:0];
                fpd_pkg::CFG_LANDING_HOLD:
                    cfg_reg.landing_hold   <= cfg_data[fpd_pkg::HOLD_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            stage_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            stage_item_reg.action <= action;
            stage_item_reg.accel  <= accel_magnitude;
            stage_item_reg.alt    <= altitude;
            stage_item_reg.now    <= now_ms;
        end
    end

    fpd_step u_step (
        .item       (stage_item_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid      = result_valid_reg;
    assign phase             = result_reg.phase;
    assign liftoff_event     = result_reg.liftoff_event;
    assign landed_event      = result_reg.landed_event;
    assign peak_altitude     = result_reg.peak;
    assign baseline_altitude = result_reg.baseline;
    assign liftoff_time      = result_reg.liftoff_time;
    assign landed_time       = result_reg.landed_time;

    a_ready_low_only_on_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        !item_ready |-> (stage_valid_reg && result_valid_reg && !result_ready))
        else $error("item_ready low without a stalled result");

    a_result_tracks_state: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance |=> (result_reg.phase == state_reg.phase
                     && result_reg.peak == state_reg.peak))
        else $error("result word differs from tracking state");

    a_idle_state_clear: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg.phase == fpd_pkg::PH_IDLE) |->
            (state_reg.peak == '0 && state_reg.liftoff_time == '0
             && state_reg.landed_time == '0))
        else $error("tracking state set while idle");

    a_liftoff_phase: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.liftoff_event) |->
            (result_reg.phase == fpd_pkg::PH_FLIGHT
             || result_reg.phase == fpd_pkg::PH_LANDED))
        else $error("liftoff event without flight phase");

    a_landed_phase: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.landed_event) |->
            (result_reg.phase == fpd_pkg::PH_LANDED))
        else $error("landed event without landed phase");

endmodule

>>> src/fpd_step.sv
// ----------------------------------------------------------------------------
// fpd_step
// next-state and result logic for one arm command or sensor sample
// ----------------------------------------------------------------------------
module fpd_step (
    input  fpd_pkg::item_t   item,
    input  fpd_pkg::state_t  state,
    input  fpd_pkg::cfg_t    cfg,
    output fpd_pkg::state_t  state_next,
    output fpd_pkg::result_t result
);

    always_comb
    begin
        fpd_pkg::state_t              st;
        logic                         lift_ev;
        logic                         land_ev;
        logic [fpd_pkg::TIME_W-1:0]   hold_start;
        logic [fpd_pkg::TIME_W-1:0]   elapsed;
        logic signed [fpd_pkg::ALT_W:0] alt_ext;
        logic [fpd_pkg::ALT_W:0]      mag;

        st      = state;
        lift_ev = 1'b0;
        land_ev = 1'b0;
        hold_start = '0;
        elapsed    = '0;
        alt_ext = {item.alt[fpd_pkg::ALT_W-1], item.alt};
        mag     = item.alt[fpd_pkg::ALT_W-1] ? (-alt_ext) : alt_ext;

        if (item.action)
        begin
            st.phase              = fpd_pkg::PH_ARMED;
            st.baseline           = item.alt;
            st.peak               = '0;
            st.liftoff_time       = '0;
            st.landed_time        = '0;
            st.accel_hold_start   = '0;
            st.landing_hold_start = '0;
        end
        else
        begin
            // peak tracking
            if ((st.phase == fpd_pkg::PH_ARMED || st.phase == fpd_pkg::PH_FLIGHT)
                && ($signed(item.alt) > $signed(st.peak)))
            begin
                st.peak = item.alt;
            end

            // liftoff
            if (st.phase == fpd_pkg::PH_ARMED)
            begin
                if (item.accel >= cfg.liftoff_accel)
                begin
                    if (st.accel_hold_start == '0)
                    begin
                        st.accel_hold_start = item.now;
                    end
                    elapsed = item.now - st.accel_hold_start;
                    if ((elapsed >= {{(fpd_pkg::TIME_W-fpd_pkg::HOLD_W){1'b0}},
                                     cfg.liftoff_hold})
                        && ($signed(st.peak) >= $signed({1'b0, cfg.min_rise})))
                    begin
                        st.phase              = fpd_pkg::PH_FLIGHT;
                        st.liftoff_time       = item.now;
                        st.landing_hold_start = '0;
                        lift_ev               = 1'b1;
                    end
                end
                else
                begin
                    st.accel_hold_start = '0;
                end
            end

            // landing, may follow liftoff on the same word
            if (st.phase == fpd_pkg::PH_FLIGHT)
            begin
                if ((item.accel <= cfg.landing_accel)
                    && (mag <= {2'b00, cfg.landing_window}))
                begin
                    hold_start = (st.landing_hold_start == '0) ? item.now
                                                               : st.landing_hold_start;
                    st.landing_hold_start = hold_start;
                    if ((item.now - hold_start) >=
                        {{(fpd_pkg::TIME_W-fpd_pkg::HOLD_W){1'b0}}, cfg.landing_hold})
                    begin
                        st.phase       = fpd_pkg::PH_LANDED;
                        st.landed_time = item.now;
                        land_ev        = 1'b1;
                    end
                end
                else
                begin
                    st.landing_hold_start = '0;
                end
            end
        end

        state_next           = st;
        result.phase         = st.phase;
        result.liftoff_event = lift_ev;
        result.landed_event  = land_ev;
        result.peak          = st.peak;
        result.baseline      = st.baseline;
        result.liftoff_time  = st.liftoff_time;
        result.landed_time   = st.landed_time;
    end

endmodule
